/* rtl/smtq_pkg.sv */
// ----------------------------------------------------------------------------
// smtq_pkg
// shared types and constants of the sorted timer expiry queue
// ----------------------------------------------------------------------------
`default_nettype none

package smtq_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int MAX_RESULTS = 32;
  localparam int FIFO_DEPTH  = 2;

  // slot index, link pointer (one code above the slots marks the end of the queue)
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int PW = $clog2(TIMER_SLOTS + 1);
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  localparam logic [PW-1:0] NO_LINK = PW'(TIMER_SLOTS);

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_SET   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_QUEUED = 2'd2,
    ST_SPARE  = 2'd3
  } status_t;

  typedef enum logic {
    RES_ALLOC  = 1'b0,
    RES_EXPIRY = 1'b1
  } res_kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [4:0]   idx;
    logic         in_range;
    logic [30:0]  delay;
    logic [31:0]  pay;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/smtq_front.sv */
// ----------------------------------------------------------------------------
// smtq_front
// command intake: classifies each word and holds it in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module smtq_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           kind,
  input  wire logic [4:0]           timer_index,
  input  wire logic [30:0]          delay_ticks,
  input  wire logic signed [31:0]   payload,
  output logic                      cmd_valid,
  output smtq_pkg::cmd_t            cmd,
  input  wire logic                 cmd_pop
);
  import smtq_pkg::*;

  cmd_t            entry [FIFO_DEPTH];
  logic [FW-1:0]   wr_ptr;
  logic [FW-1:0]   rd_ptr;
  logic [FCW-1:0]  fill;
  logic            push;
  cmd_t            in_cmd;

  assign busy      = (fill == FCW'(FIFO_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (fill != '0);
  assign cmd       = entry[rd_ptr];

  always_comb begin
    in_cmd.kind     = kind_t'(kind);
    in_cmd.idx      = timer_index;
    in_cmd.in_range = (32'(timer_index) < 32'(TIMER_SLOTS));
    in_cmd.delay    = delay_ticks;
    in_cmd.pay      = payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= in_cmd;
        wr_ptr <= (wr_ptr == FW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == FW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + FCW'(push) - FCW'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/smtq_back.sv */
// ----------------------------------------------------------------------------
// smtq_back
// command sequencer: scans the slot status on allocate and walks the sorted queue one entry a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smtq_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire smtq_pkg::cmd_t       cmd,
  output logic                      cmd_pop,
  output logic                      strobe,
  output logic                      result_kind,
  output logic [4:0]                slot,
  output logic                      alloc_ok,
  output logic signed [31:0]        expired_payload,
  output logic                      last
);
  import smtq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TICK   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_UNLINK = 6'b001000,
    S_SETUP  = 6'b010000,
    S_INSERT = 6'b100000
  } state_t;

  state_t          state;
  logic [31:0]     expiry  [TIMER_SLOTS];
  logic [31:0]     pay_mem [TIMER_SLOTS];
  logic [PW-1:0]   link    [TIMER_SLOTS];
  status_t         status  [TIMER_SLOTS];

  logic [31:0]     tick_count;
  logic [PW-1:0]   head;
  logic [PW-1:0]   cur;
  logic [PW-1:0]   prev;
  logic [PW-1:0]   idx;
  logic [IW-1:0]   scan;
  logic [PW-1:0]   guard;
  logic [CW-1:0]   count;
  logic            is_set;
  logic [30:0]     delay;
  logic [31:0]     pay;
  logic [31:0]     t_new;

  // held back one step so that the final report can carry last
  logic            pend_valid;
  logic [PW-1:0]   pend_slot;
  logic [31:0]     pend_pay;

  logic [IW-1:0]   cur_i;
  logic [IW-1:0]   idx_i;
  logic [PW-1:0]   cmd_idx_p;
  logic [IW-1:0]   stat_addr;
  status_t         stat_rd;
  logic            cur_ok;
  logic            walk_ok;
  logic            due;

  assign cur_i     = cur[IW-1:0];
  assign idx_i     = idx[IW-1:0];
  assign cmd_idx_p = PW'(cmd.idx);
  assign stat_addr = (state == S_SCAN) ? scan : cmd_idx_p[IW-1:0];
  assign stat_rd   = status[stat_addr];
  assign cur_ok    = (cur < NO_LINK);
  assign walk_ok   = cur_ok && (guard < PW'(TIMER_SLOTS));
  assign due       = cur_ok && (count < CW'(MAX_RESULTS)) && (expiry[cur_i] <= tick_count);
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      head       <= NO_LINK;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) status[i] <= ST_UNUSED;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            idx    <= cmd_idx_p;
            is_set <= (cmd.kind == KIND_SET);
            delay  <= cmd.delay;
            pay    <= cmd.pay;
            prev   <= NO_LINK;
            cur    <= head;
            guard  <= '0;
            count  <= '0;
            scan   <= '0;
            unique case (cmd.kind)
              KIND_TICK: begin
                tick_count <= tick_count + 32'd1;
                state      <= S_TICK;
              end
              KIND_ALLOC: state <= S_SCAN;
              KIND_FREE: begin
                if (cmd.in_range) begin
                  if (stat_rd == ST_QUEUED) state <= S_UNLINK;
                  else status[cmd_idx_p[IW-1:0]] <= ST_UNUSED;
                end
              end
              KIND_SET: begin
                if (cmd.in_range) begin
                  if (stat_rd == ST_QUEUED) state <= S_UNLINK;
                  else if (stat_rd != ST_UNUSED) state <= S_SETUP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TICK: begin
          if (due) begin
            status[cur_i] <= ST_ALLOC;
            head          <= link[cur_i];
            cur           <= link[cur_i];
            count         <= count + 1'b1;
            pend_valid    <= 1'b1;
            pend_slot     <= cur;
            pend_pay      <= pay_mem[cur_i];
          end else begin
            state <= S_IDLE;
          end
          // previous report goes out now; last when the walk stops here
          if (pend_valid) begin
            strobe          <= 1'b1;
            result_kind     <= RES_EXPIRY;
            slot            <= 5'(pend_slot);
            alloc_ok        <= 1'b0;
            expired_payload <= pend_pay;
            last            <= !due;
          end
          if (!due) pend_valid <= 1'b0;
        end
        S_SCAN: begin
          if (stat_rd == ST_UNUSED) begin
            status[scan]    <= ST_ALLOC;
            strobe          <= 1'b1;
            result_kind     <= RES_ALLOC;
            slot            <= 5'(scan);
            alloc_ok        <= 1'b1;
            expired_payload <= '0;
            last            <= 1'b1;
            state           <= S_IDLE;
          end else if (scan == IW'(TIMER_SLOTS - 1)) begin
            strobe          <= 1'b1;
            result_kind     <= RES_ALLOC;
            slot            <= '0;
            alloc_ok        <= 1'b0;
            expired_payload <= '0;
            last            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_UNLINK: begin
          if (walk_ok && cur != idx) begin
            prev  <= cur;
            cur   <= link[cur_i];
            guard <= guard + 1'b1;
          end else begin
            if (walk_ok) begin
              if (prev == NO_LINK) head <= link[cur_i];
              else link[prev[IW-1:0]] <= link[cur_i];
            end
            if (is_set) begin
              state <= S_SETUP;
            end else begin
              status[idx_i] <= ST_UNUSED;
              state         <= S_IDLE;
            end
          end
        end
        S_SETUP: begin
          expiry[idx_i]  <= t_new;
          pay_mem[idx_i] <= pay;
          status[idx_i]  <= ST_QUEUED;
          cur            <= head;
          prev           <= NO_LINK;
          guard          <= '0;
          state          <= S_INSERT;
        end
        S_INSERT: begin
          if (walk_ok && !(expiry[idx_i] <= expiry[cur_i])) begin
            prev  <= cur;
            cur   <= link[cur_i];
            guard <= guard + 1'b1;
          end else begin
            link[idx_i] <= cur_ok ? cur : NO_LINK;
            if (prev == NO_LINK) head <= idx;
            else link[prev[IW-1:0]] <= idx;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign t_new = tick_count + {1'b0, delay};

endmodule

`default_nettype wire

/* rtl/sorted_multi_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_multi_timer_queue
// pool of timers kept as a linked queue sorted by expiry time
// ----------------------------------------------------------------------------
//  channel   handshake        word fields
//  command   start / busy     kind, timer_index, delay_ticks, payload
//  result    strobe           result_kind, slot, alloc_ok, expired_payload, last
//
//  a tick takes expired timers from the queue head, up to 32 of them
//  allocate scans the slot status one slot a cycle until it finds an unused slot
//  free walks the queue one link a cycle to unlink a queued timer; set walks it to insert, twice if already queued
//  reset is synchronous; all slots unused, queue empty, tick count zero
//  busy rises only when the two-word command queue is full; results cannot be stalled
`default_nettype none

module sorted_multi_timer_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           kind,
  input  wire logic [4:0]           timer_index,
  input  wire logic [30:0]          delay_ticks,
  input  wire logic signed [31:0]   payload,
  output logic                      strobe,
  output logic                      result_kind,
  output logic [4:0]                slot,
  output logic                      alloc_ok,
  output logic signed [31:0]        expired_payload,
  output logic                      last
);
  import smtq_pkg::*;

  // words waiting between intake and sequencer
  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;

  smtq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .timer_index (timer_index),
    .delay_ticks (delay_ticks),
    .payload     (payload),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // sequencer owns all timer state and drives the result strobe
  smtq_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .strobe          (strobe),
    .result_kind     (result_kind),
    .slot            (slot),
    .alloc_ok        (alloc_ok),
    .expired_payload (expired_payload),
    .last            (last)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("sequencer took a word from an empty queue");

  a_alloc_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == RES_ALLOC) |-> (last && expired_payload == 32'sd0))
    else $error("allocation answer not a single final word");

  a_alloc_then_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == RES_ALLOC) |=> !strobe)
    else $error("result followed an allocation answer at once");

  a_expiry_not_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && result_kind == RES_EXPIRY) |-> !alloc_ok)
    else $error("expiry report flagged as allocation");
`endif

endmodule

`default_nettype wire
